>>> rtl/core/aptb_pkg.sv
// Shared types and constants for the aged point trail buffer.
package aptb_pkg;

  // Request kinds.
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_DRAW  = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [31:0] LIFETIME_DEFAULT = 32'd32768;
  localparam logic [33:0] DUP_LIMIT        = 34'd4295;

  // Width of one stored point word.
  localparam int PT_W = 128;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        delta_time;
    logic [7:0]         base_red;
    logic [7:0]         base_green;
    logic [7:0]         base_blue;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic [7:0]         faded_red;
    logic [7:0]         faded_green;
    logic [7:0]         faded_blue;
    logic               last_segment;
  } out_item_t;

  // One stored point: position and age.
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] age;
  } point_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;     // capture the request
    logic dup_start;    // register the duplicate test against the newest point
    logic shift_step;   // move one entry one place older
    logic write_new;    // write the new point at the newest slot
    logic age_step;     // add dt to one entry
    logic draw_rd;      // hold the newer point of a draw pair
    logic div_start;    // start the fade division
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dup;
    logic div_done;
    logic expired;
  } stat_t;

endpackage

>>> rtl/core/aptb_ram.sv
// Generic RAM with one write port, one read port and registered read.
module aptb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/aptb_datapath.sv
// Datapath: point memory, duplicate test, age update and fade divider.
module aptb_datapath #(
  parameter int TRAIL_DEPTH = 32,
  localparam int AW = $clog2(TRAIL_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  aptb_pkg::in_item_t   req,
  input  logic [31:0]          lifetime,
  input  aptb_pkg::cmd_t       cmd,
  input  logic [AW-1:0]        raddr,
  input  logic [AW-1:0]        waddr,
  input  logic                 last,
  output aptb_pkg::stat_t      stat,
  output aptb_pkg::out_item_t  out_nxt
);

  aptb_pkg::in_item_t req_r;
  aptb_pkg::point_t   rd;
  aptb_pkg::point_t   wdata;
  aptb_pkg::point_t   prev_r;
  logic               we;
  logic [31:0]        eff_l;
  logic [32:0]        age_sum;
  logic [32:0]        dx, dy, dz;
  logic [32:0]        mx, my, mz;
  logic               far;
  logic [33:0]        acc;
  logic               dup_r;
  // Fade divider: 9 quotient bits, one per cycle.
  logic [40:0]        rem_r, rem_nxt;
  logic [8:0]         q_r, q_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [41:0]        div_d;
  logic [41:0]        rem_sh;
  logic [8:0]         fade;

  assign eff_l = (lifetime == 32'd0) ? aptb_pkg::LIFETIME_DEFAULT : lifetime;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= req;
    end
  end

  // Memory write data selection.
  assign age_sum = {1'b0, rd.age} + {1'b0, req_r.delta_time};
  always_comb begin
    we    = cmd.shift_step | cmd.write_new | cmd.age_step;
    wdata = rd;
    if (cmd.write_new) begin
      wdata = '{x: req_r.pos_x, y: req_r.pos_y, z: req_r.pos_z, age: 32'd0};
    end else if (cmd.age_step) begin
      wdata.age = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    end
  end

  aptb_ram #(.WIDTH(aptb_pkg::PT_W), .DEPTH(TRAIL_DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rd)
  );

  // Duplicate test against the newest point (read data valid now).
  assign dx = {req_r.pos_x[31], req_r.pos_x} - {rd.x[31], rd.x};
  assign dy = {req_r.pos_y[31], req_r.pos_y} - {rd.y[31], rd.y};
  assign dz = {req_r.pos_z[31], req_r.pos_z} - {rd.z[31], rd.z};
  assign mx = dx[32] ? -dx : dx;
  assign my = dy[32] ? -dy : dy;
  assign mz = dz[32] ? -dz : dz;
  assign far = (mx[32:16] != '0) | (my[32:16] != '0) | (mz[32:16] != '0);
  assign acc = {2'b0, 32'(mx[15:0]) * 32'(mx[15:0])}
             + {2'b0, 32'(my[15:0]) * 32'(my[15:0])}
             + {2'b0, 32'(mz[15:0]) * 32'(mz[15:0])};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
    end else if (cmd.dup_start) begin
      dup_r <= !far && (acc < aptb_pkg::DUP_LIMIT);
    end
  end

  assign stat.dup     = dup_r;
  assign stat.expired = rd.age > eff_l;

  // Hold the newer point of a draw pair.
  always_ff @(posedge clk) begin
    if (cmd.draw_rd) begin
      prev_r <= rd;
    end
  end

  // Restoring divider: (L - age) * 256 / L, the remainder shifted left each
  // step and compared against L * 512.
  assign div_d  = {1'b0, eff_l, 9'd0};
  assign rem_sh = {rem_r, 1'b0};
  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cmd.div_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      q_nxt    = '0;
      rem_nxt  = (prev_r.age >= eff_l) ? 41'd0 : {1'b0, eff_l - prev_r.age, 8'd0};
    end else if (busy_r) begin
      if (cnt_r == 4'd9) begin
        busy_nxt = 1'b0;
      end else begin
        if (rem_sh >= div_d) begin
          rem_nxt = 41'(rem_sh - div_d);
          q_nxt   = {q_r[7:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[40:0];
          q_nxt   = {q_r[7:0], 1'b0};
        end
        cnt_nxt = cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign stat.div_done = busy_r && (cnt_r == 4'd9);
  assign fade = q_r;

  // Output item, built from the held pair and the quotient.
  always_comb begin
    logic [16:0] pr, pg, pb;
    pr = req_r.base_red * fade;
    pg = req_r.base_green * fade;
    pb = req_r.base_blue * fade;
    out_nxt.start_x      = prev_r.x;
    out_nxt.start_y      = prev_r.y;
    out_nxt.start_z      = prev_r.z;
    out_nxt.end_x        = rd.x;
    out_nxt.end_y        = rd.y;
    out_nxt.end_z        = rd.z;
    out_nxt.faded_red    = pr[15:8];
    out_nxt.faded_green  = pg[15:8];
    out_nxt.faded_blue   = pb[15:8];
    out_nxt.last_segment = last;
  end

endmodule

>>> rtl/core/aptb_ctrl.sv
// Controller state machine sequencing push, tick, draw and clear.
module aptb_ctrl #(
  parameter int TRAIL_DEPTH = 32,
  localparam int AW = $clog2(TRAIL_DEPTH),
  localparam int CW = $clog2(TRAIL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_stall,
  input  logic              out_free,
  output logic              out_load,
  input  aptb_pkg::stat_t   stat,
  output aptb_pkg::cmd_t    cmd,
  output logic [AW-1:0]     raddr,
  output logic [AW-1:0]     waddr,
  output logic              last
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DUPRD  = 4'd1;
  localparam logic [3:0] S_DUP    = 4'd2;
  localparam logic [3:0] S_SHIFT  = 4'd3;
  localparam logic [3:0] S_AGERD  = 4'd4;
  localparam logic [3:0] S_AGE    = 4'd5;
  localparam logic [3:0] S_TRIMRD = 4'd6;
  localparam logic [3:0] S_TRIM   = 4'd7;
  localparam logic [3:0] S_DRD0   = 4'd8;
  localparam logic [3:0] S_DRD1   = 4'd9;
  localparam logic [3:0] S_DIV    = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;
  localparam logic [3:0] S_SHRD   = 4'd12;
  localparam logic [3:0] S_NEWPT  = 4'd13;
  localparam logic [3:0] S_DIVW   = 4'd14;

  localparam logic [CW-1:0] MAXP = CW'(TRAIL_DEPTH);

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  assign in_stall = (state_r != S_IDLE);
  assign raddr    = idx_r[AW-1:0];
  assign last     = ({1'b0, idx_r} + 1'b1) == {1'b0, held_r};

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    out_load  = 1'b0;
    waddr     = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          idx_nxt      = '0;
          case (in_kind)
            aptb_pkg::KIND_PUSH:  state_nxt = (held_r == '0) ? S_NEWPT : S_DUPRD;
            aptb_pkg::KIND_TICK:  state_nxt = (held_r == '0) ? S_IDLE : S_AGERD;
            aptb_pkg::KIND_DRAW:  state_nxt = (held_r < CW'(2)) ? S_IDLE : S_DRD0;
            default: begin
              held_nxt  = '0;
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // Read the newest point, then test it.
      S_DUPRD: state_nxt = S_DUP;
      S_DUP: begin
        cmd.dup_start = 1'b1;
        state_nxt = S_SHRD;
        idx_nxt = (held_r == MAXP) ? held_r - CW'(2) : held_r - CW'(1);
      end
      // Shift from the oldest kept entry toward the newest.
      S_SHRD: begin
        if (stat.dup) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        waddr = AW'(idx_r + CW'(1));
        if (idx_r == '0) begin
          state_nxt = S_NEWPT;
        end else begin
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_SHRD;
        end
      end
      S_NEWPT: begin
        cmd.write_new = 1'b1;
        waddr = '0;
        if (held_r != MAXP) begin
          held_nxt = held_r + CW'(1);
        end
        state_nxt = S_IDLE;
      end
      // Age each entry: read then write.
      S_AGERD: state_nxt = S_AGE;
      S_AGE: begin
        cmd.age_step = 1'b1;
        if (idx_r == held_r - CW'(1)) begin
          state_nxt = S_TRIMRD;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_AGERD;
        end
      end
      // Trim expired entries from the oldest end; idx already points there.
      S_TRIMRD: state_nxt = S_TRIM;
      S_TRIM: begin
        if (stat.expired) begin
          held_nxt = held_r - CW'(1);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - CW'(1);
            state_nxt = S_TRIMRD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Draw: read newer point, then older point while dividing.
      S_DRD0: state_nxt = S_DRD1;
      S_DRD1: begin
        cmd.draw_rd = 1'b1;
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (stat.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_DRD1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> rtl/core/aged_point_trail_buffer.sv
// Top level of the aged point trail buffer.
// The block takes one request at a time. A push shifts the held points one
// entry older, one entry at a time; a tick ages every point and drops
// expired points from the oldest end; a clear empties the buffer; a draw
// emits one segment per pair of points, faded by the 9-step fade divider;
// a stalled result holds the draw. The lifetime register is written on the
// cfg port only while the block is idle and no request is offered.
module aged_point_trail_buffer #(
  parameter int TRAIL_DEPTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aptb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aptb_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int AW = $clog2(TRAIL_DEPTH);

  logic [31:0]         life_r;
  aptb_pkg::cmd_t      cmd;
  aptb_pkg::stat_t     stat;
  aptb_pkg::out_item_t out_nxt;
  logic [AW-1:0]       raddr, waddr;
  logic                last, out_load, out_free;

  // Configuration is taken only with nothing in work and no request offered.
  assign cfg_ready = !in_stall && !in_valid;

  // Lifetime register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= aptb_pkg::LIFETIME_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      life_r <= cfg_data;
    end
  end

  assign out_free = !out_valid || !out_stall;

  aptb_ctrl #(.TRAIL_DEPTH(TRAIL_DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_kind(in_data.kind),
    .in_stall(in_stall), .out_free(out_free), .out_load(out_load),
    .stat(stat), .cmd(cmd), .raddr(raddr), .waddr(waddr), .last(last)
  );

  aptb_datapath #(.TRAIL_DEPTH(TRAIL_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_data), .lifetime(life_r), .cmd(cmd),
    .raddr(raddr), .waddr(waddr), .last(last), .stat(stat), .out_nxt(out_nxt)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data <= out_nxt;
    end
  end

endmodule

>>> rtl/core/aptb_checker.sv
// Port-level checker for the aged point trail buffer, with its bind.
module aptb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input aptb_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input aptb_pkg::out_item_t out_data,
  input logic                cfg_ready
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // A new result is only produced while a request is in work.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // A clear returns the block to idle in the next cycle.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == aptb_pkg::KIND_CLEAR |=> !in_stall)
    else $error("clear did not finish");

  // Configuration is taken only while idle with no request offered.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !in_stall && !in_valid)
    else $error("cfg ready while busy");

endmodule

bind aged_point_trail_buffer aptb_checker u_chk (.*);
